/* rtl/gwf_pkg.sv */
`default_nettype none

package gwf_pkg;

    // field widths of the channels
    localparam int OP_W       = 2;
    localparam int COORD_W    = 5;
    localparam int KIND_W     = 3;
    localparam int IDX_W      = 7;
    localparam int HEAD_W     = 2;
    localparam int TURN_W     = 3;
    localparam int LEN_W      = 8;
    localparam int ENTRY_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_STEP    = 2'd1,
        OP_READ    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    localparam logic [KIND_W-1:0] KIND_BLANK = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TRACK = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GOAL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ROBOT = 3'd3;

    localparam logic [TURN_W-1:0] TURN_NONE  = 3'd0;
    localparam logic [TURN_W-1:0] TURN_LEFT  = 3'd1;
    localparam logic [TURN_W-1:0] TURN_FWD   = 3'd2;
    localparam logic [TURN_W-1:0] TURN_RIGHT = 3'd3;
    localparam logic [TURN_W-1:0] TURN_BACK  = 3'd4;

    // turn codes as held on the path stack
    localparam logic [ENTRY_W-1:0] PT_L = 2'd0;
    localparam logic [ENTRY_W-1:0] PT_F = 2'd1;
    localparam logic [ENTRY_W-1:0] PT_R = 2'd2;
    localparam logic [ENTRY_W-1:0] PT_B = 2'd3;

    localparam logic [HEAD_W-1:0] DIR_N = 2'd0;
    localparam logic [HEAD_W-1:0] DIR_E = 2'd1;
    localparam logic [HEAD_W-1:0] DIR_S = 2'd2;
    localparam logic [HEAD_W-1:0] DIR_W = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd2;

    localparam logic [COORD_W-1:0] START_ROW_RST  = 5'd12;
    localparam logic [COORD_W-1:0] START_COL_RST  = 5'd1;
    localparam logic [HEAD_W-1:0]  START_HEAD_RST = 2'd1;

    // source of the map write port
    typedef enum logic [2:0] {
        GW_NONE  = 3'd0,
        GW_CLEAR = 3'd1,
        GW_CELL  = 3'd2,
        GW_OLD   = 3'd3,
        GW_NEW   = 3'd4
    } t_gw;

    typedef struct packed {
        logic in_ready;
        logic item_load;
        logic rd_sw;
        logic cap_ne;
        logic cap_sw;
        t_gw  gw_sel;
        logic clr_step;
        logic restart;
        logic dec_load;
        logic move;
        logic push;
        logic red_rd;
        logic red_wr;
        logic entry_cap;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        t_op  op;
        logic clr_last;
        logic goal;
        logic push_req;
        logic full;
        logic ge3;
        logic red_hit;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] res;
    } t_red;

    // x-back-y shortening of the three turns at the top of the stack
    function automatic t_red reduce_rule(input logic [ENTRY_W-1:0] a,
                                         input logic [ENTRY_W-1:0] c);
        t_red r;
        r.hit = 1'b1;
        r.res = PT_B;
        priority if (a == PT_L && c == PT_R) begin
            r.res = PT_B;
        end else if (a == PT_L && c == PT_F) begin
            r.res = PT_R;
        end else if (a == PT_R && c == PT_L) begin
            r.res = PT_B;
        end else if (a == PT_F && c == PT_L) begin
            r.res = PT_R;
        end else if (a == PT_F && c == PT_F) begin
            r.res = PT_B;
        end else if (a == PT_L && c == PT_L) begin
            r.res = PT_F;
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [ENTRY_W-1:0] turn_code(input logic [TURN_W-1:0] t);
        logic [ENTRY_W-1:0] c;
        unique case (t)
            TURN_LEFT:  c = PT_L;
            TURN_FWD:   c = PT_F;
            TURN_RIGHT: c = PT_R;
            default:    c = PT_B;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/gwf_if.sv */
`default_nettype none

interface gwf_item_if import gwf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic [KIND_W-1:0]  cell_kind;
    logic [IDX_W-1:0]   entry_index;

    modport source (output valid, operation, cell_row, cell_col, cell_kind, entry_index,
                    input ready);
    modport sink (input valid, operation, cell_row, cell_col, cell_kind, entry_index,
                  output ready);
endinterface

interface gwf_result_if import gwf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] robot_row;
    logic [COORD_W-1:0] robot_col;
    logic [HEAD_W-1:0]  robot_heading;
    logic [TURN_W-1:0]  turn_taken;
    logic               reached_goal;
    logic [LEN_W-1:0]   path_length;
    logic [ENTRY_W-1:0] path_entry;
    logic               path_overflow;

    modport source (output valid, robot_row, robot_col, robot_heading, turn_taken,
                    reached_goal, path_length, path_entry, path_overflow,
                    input ready);
    modport sink (input valid, robot_row, robot_col, robot_heading, turn_taken,
                  reached_goal, path_length, path_entry, path_overflow,
                  output ready);
endinterface

interface gwf_cfg_if import gwf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/grid_wall_follower_with_path_reduction.sv */
// Left-hand maze walker over a square map with online path shortening.
// Item channel (i_item): one operation per transfer: write a map cell, take
// one robot step, read an entry of the shortened path, or restart the robot.
// Result channel (o_result): exactly one result per item, in order, giving
// the robot's position, heading, the turn of a step, the goal flag, the path
// length, the read entry and the overflow flag.
// Configuration channel (i_cfg): start row, start column and start heading;
// always ready, used only at the next restart.
// Items are handled one at a time: a map write, a restart, a path read, a step
// that stays put with the goal in sight, a corridor move, or a turn, which pushes
// its code and then checks a rule after each push or shortening while the stack
// holds three or more turns; a turn on a full stack pushes nothing and checks none.
// The next item is taken in the cycle after its result is loaded.
// The map sits in a memory with one write and two read ports, so the neighbours
// are read north and east first, then south and west, and the path stack is
// shortened one rule a pass.
// After reset the map is cleared one cell a cycle, all GRID_SIDE * GRID_SIDE
// cells (1024 at the default), before the first item is taken.
// The result is held in an output register; while the receiver stalls the
// next item is still taken and worked on, and it waits only to deliver.
`default_nettype none

module grid_wall_follower_with_path_reduction import gwf_pkg::*; #(
    parameter int GRID_SIDE  = 32,
    parameter int PATH_DEPTH = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gwf_item_if.sink     i_item,
    gwf_result_if.source o_result,
    gwf_cfg_if.sink      i_cfg
);

    t_cmd w_cmd;
    t_sts w_sts;

    gwf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    gwf_dp #(
        .GRID_SIDE  (GRID_SIDE),
        .PATH_DEPTH (PATH_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts)
    );

endmodule

`default_nettype wire

/* rtl/gwf_dp.sv */
`default_nettype none

module gwf_dp import gwf_pkg::*; #(
    parameter int GRID_SIDE  = 32,
    parameter int PATH_DEPTH = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gwf_item_if.sink     i_item,
    gwf_result_if.source o_result,
    gwf_cfg_if.sink      i_cfg,
    input  t_cmd         i_cmd,
    output t_sts         o_sts
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int SAW   = $clog2(PATH_DEPTH);
    localparam int CW    = $clog2(PATH_DEPTH + 1);
    localparam int XW    = (CW > IDX_W) ? CW : IDX_W;
    // neighbour coordinates, wide enough that a step off the low edge reads as off-grid
    localparam int NW    = 7;

    // configuration and robot state
    logic [COORD_W-1:0] r_start_row, r_start_col, r_row, r_col;
    logic [HEAD_W-1:0]  r_start_head, r_head;
    logic [CW-1:0]      r_count;
    logic               r_ovf;
    logic [AW-1:0]      r_clr;
    logic               r_out_valid;

    // item and working registers
    logic [OP_W-1:0]    r_op;
    logic [COORD_W-1:0] r_crow, r_ccol;
    logic [KIND_W-1:0]  r_ckind;
    logic [IDX_W-1:0]   r_idx;
    logic [KIND_W-1:0]  r_nb [4];
    logic [HEAD_W-1:0]  r_dir;
    logic [TURN_W-1:0]  r_turn;
    logic               r_push;
    logic [ENTRY_W-1:0] r_top;
    logic [ENTRY_W-1:0] r_entry;

    // result register
    logic [COORD_W-1:0] r_o_row, r_o_col;
    logic [HEAD_W-1:0]  r_o_head;
    logic [TURN_W-1:0]  r_o_turn;
    logic               r_o_goal;
    logic [LEN_W-1:0]   r_o_len;
    logic [ENTRY_W-1:0] r_o_entry;
    logic               r_o_ovf;

    // memories
    logic [KIND_W-1:0]  r_grid [CELLS];
    logic [KIND_W-1:0]  r_grd0, r_grd1;
    logic [ENTRY_W-1:0] r_stk [PATH_DEPTH];
    logic [ENTRY_W-1:0] r_srd0, r_srd1;

    function automatic logic [AW-1:0] gaddr(input logic [NW-1:0] r, input logic [NW-1:0] c);
        return AW'(int'(r) * GRID_SIDE + int'(c));
    endfunction

    // neighbour addresses in the order north, east, south, west
    logic [NW-1:0] w_nrow [4];
    logic [NW-1:0] w_ncol [4];
    logic          w_nval [4];
    logic [AW-1:0] w_naddr [4];
    logic [NW-1:0] w_row7, w_col7;

    always_comb begin
        w_row7 = {2'b00, r_row};
        w_col7 = {2'b00, r_col};
        w_nrow[0] = w_row7 - NW'(1);
        w_ncol[0] = w_col7;
        w_nrow[1] = w_row7;
        w_ncol[1] = w_col7 + NW'(1);
        w_nrow[2] = w_row7 + NW'(1);
        w_ncol[2] = w_col7;
        w_nrow[3] = w_row7;
        w_ncol[3] = w_col7 - NW'(1);
        for (int d = 0; d < 4; d++) begin
            w_nval[d]  = (int'(w_nrow[d]) < GRID_SIDE) && (int'(w_ncol[d]) < GRID_SIDE);
            w_naddr[d] = gaddr(w_nrow[d], w_ncol[d]);
        end
    end

    logic [AW-1:0]     w_ga0, w_ga1, w_gwa, w_paddr, w_caddr;
    logic              w_gwe, w_pin, w_cin;
    logic [KIND_W-1:0] w_gwd;

    assign w_ga0   = i_cmd.rd_sw ? w_naddr[2] : w_naddr[0];
    assign w_ga1   = i_cmd.rd_sw ? w_naddr[3] : w_naddr[1];
    assign w_paddr = gaddr(w_row7, w_col7);
    assign w_pin   = (int'(r_row) < GRID_SIDE) && (int'(r_col) < GRID_SIDE);
    assign w_caddr = gaddr({2'b00, r_crow}, {2'b00, r_ccol});
    assign w_cin   = (int'(r_crow) < GRID_SIDE) && (int'(r_ccol) < GRID_SIDE);

    always_comb begin
        w_gwe = 1'b0;
        w_gwa = w_paddr;
        w_gwd = KIND_BLANK;
        unique case (i_cmd.gw_sel)
            GW_NONE: begin
                w_gwe = 1'b0;
            end
            GW_CLEAR: begin
                w_gwe = 1'b1;
                w_gwa = r_clr;
                w_gwd = KIND_BLANK;
            end
            GW_CELL: begin
                w_gwe = w_cin;
                w_gwa = w_caddr;
                w_gwd = r_ckind;
            end
            GW_OLD: begin
                w_gwe = w_pin;
                w_gwd = KIND_TRACK;
            end
            GW_NEW: begin
                w_gwe = w_pin;
                w_gwd = KIND_ROBOT;
            end
            default: begin
                w_gwe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_gwe) begin
            r_grid[w_gwa] <= w_gwd;
        end
        r_grd0 <= r_grid[w_ga0];
        r_grd1 <= r_grid[w_ga1];
    end

    // step decision from the four captured neighbours
    logic [HEAD_W-1:0] w_fwd, w_left, w_right, w_back, w_dir, w_mdir;
    logic [TURN_W-1:0] w_turn;
    logic              w_goal, w_corr, w_mpush;

    assign w_fwd   = r_head;
    assign w_left  = r_head + 2'd3;
    assign w_right = r_head + 2'd1;
    assign w_back  = r_head + 2'd2;
    assign w_goal  = (r_nb[0] == KIND_GOAL) || (r_nb[1] == KIND_GOAL) ||
                     (r_nb[2] == KIND_GOAL) || (r_nb[3] == KIND_GOAL);
    assign w_corr  = (r_nb[w_left] == KIND_BLANK) && (r_nb[w_right] == KIND_BLANK) &&
                     (r_nb[w_fwd] == KIND_TRACK);

    always_comb begin
        w_dir   = w_fwd;
        w_turn  = TURN_NONE;
        w_mpush = 1'b0;
        priority if (w_goal) begin
            w_turn = TURN_NONE;
        end else if (w_corr) begin
            w_dir = w_fwd;
        end else if (r_nb[w_left] == KIND_TRACK) begin
            w_dir   = w_left;
            w_turn  = TURN_LEFT;
            w_mpush = 1'b1;
        end else if (r_nb[w_fwd] == KIND_TRACK) begin
            w_dir   = w_fwd;
            w_turn  = TURN_FWD;
            w_mpush = 1'b1;
        end else if (r_nb[w_right] == KIND_TRACK) begin
            w_dir   = w_right;
            w_turn  = TURN_RIGHT;
            w_mpush = 1'b1;
        end else begin
            w_dir   = w_back;
            w_turn  = TURN_BACK;
            w_mpush = 1'b1;
        end
    end

    // new position, wrapping in the coordinate registers
    logic [COORD_W-1:0] w_mrow, w_mcol;

    assign w_mdir = r_dir;

    always_comb begin
        w_mrow = r_row;
        w_mcol = r_col;
        unique case (w_mdir)
            DIR_N: w_mrow = r_row - 5'd1;
            DIR_E: w_mcol = r_col + 5'd1;
            DIR_S: w_mrow = r_row + 5'd1;
            DIR_W: w_mcol = r_col - 5'd1;
        endcase
    end

    // path stack
    logic [SAW-1:0]     w_sa0, w_sa1, w_swa, w_idx_addr;
    logic               w_swe, w_full, w_ge3, w_entry_ok;
    logic [ENTRY_W-1:0] w_swd;
    t_red               w_red;

    assign w_full     = int'(r_count) >= PATH_DEPTH;
    assign w_ge3      = r_count >= CW'(3);
    assign w_idx_addr = SAW'(r_idx);
    assign w_entry_ok = XW'(r_idx) < XW'(r_count);
    assign w_sa0      = i_cmd.red_rd ? SAW'(r_count - CW'(2)) : w_idx_addr;
    assign w_sa1      = SAW'(r_count - CW'(3));
    assign w_red      = reduce_rule(r_srd1, r_top);

    always_comb begin
        w_swe = 1'b0;
        w_swa = SAW'(r_count);
        w_swd = turn_code(r_turn);
        priority if (i_cmd.push) begin
            w_swe = !w_full;
        end else if (i_cmd.red_wr) begin
            w_swe = 1'b1;
            w_swa = w_sa1;
            w_swd = w_red.res;
        end else begin
            w_swe = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_stk[w_swa] <= w_swd;
        end
        r_srd0 <= r_stk[w_sa0];
        r_srd1 <= r_stk[w_sa1];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row  <= START_ROW_RST;
            r_start_col  <= START_COL_RST;
            r_start_head <= START_HEAD_RST;
            r_row        <= START_ROW_RST;
            r_col        <= START_COL_RST;
            r_head       <= START_HEAD_RST;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_START_ROW:  r_start_row  <= i_cfg.data;
                    CFG_START_COL:  r_start_col  <= i_cfg.data;
                    CFG_START_HEAD: r_start_head <= i_cfg.data[HEAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.restart) begin
                r_row   <= r_start_row;
                r_col   <= r_start_col;
                r_head  <= r_start_head;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.move) begin
                r_row  <= w_mrow;
                r_col  <= w_mcol;
                r_head <= r_dir;
            end
            if (i_cmd.push) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.red_wr) begin
                r_count <= r_count - CW'(2);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_op    <= i_item.operation;
            r_crow  <= i_item.cell_row;
            r_ccol  <= i_item.cell_col;
            r_ckind <= i_item.cell_kind;
            r_idx   <= i_item.entry_index;
            r_turn  <= TURN_NONE;
            r_entry <= '0;
        end
        if (i_cmd.cap_ne) begin
            r_nb[0] <= w_nval[0] ? r_grd0 : KIND_BLANK;
            r_nb[1] <= w_nval[1] ? r_grd1 : KIND_BLANK;
        end
        if (i_cmd.cap_sw) begin
            r_nb[2] <= w_nval[2] ? r_grd0 : KIND_BLANK;
            r_nb[3] <= w_nval[3] ? r_grd1 : KIND_BLANK;
        end
        if (i_cmd.dec_load) begin
            r_dir  <= w_dir;
            r_turn <= w_turn;
            r_push <= w_mpush;
        end
        if (i_cmd.push && !w_full) begin
            r_top <= turn_code(r_turn);
        end
        if (i_cmd.red_wr) begin
            r_top <= w_red.res;
        end
        if (i_cmd.entry_cap) begin
            r_entry <= w_entry_ok ? r_srd0 : '0;
        end
        if (i_cmd.out_load) begin
            r_o_row   <= r_row;
            r_o_col   <= r_col;
            r_o_head  <= r_head;
            r_o_turn  <= r_turn;
            r_o_goal  <= w_goal;
            r_o_len   <= LEN_W'(r_count);
            r_o_entry <= r_entry;
            r_o_ovf   <= r_ovf;
        end
    end

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = i_cmd.in_ready;

    assign o_result.valid         = r_out_valid;
    assign o_result.robot_row     = r_o_row;
    assign o_result.robot_col     = r_o_col;
    assign o_result.robot_heading = r_o_head;
    assign o_result.turn_taken    = r_o_turn;
    assign o_result.reached_goal  = r_o_goal;
    assign o_result.path_length   = r_o_len;
    assign o_result.path_entry    = r_o_entry;
    assign o_result.path_overflow = r_o_ovf;

    assign o_sts.in_valid = i_item.valid;
    assign o_sts.op       = t_op'(r_op);
    assign o_sts.clr_last = (r_clr == AW'(CELLS - 1));
    assign o_sts.goal     = w_goal;
    assign o_sts.push_req = r_push;
    assign o_sts.full     = w_full;
    assign o_sts.ge3      = w_ge3;
    assign o_sts.red_hit  = (r_srd0 == PT_B) && w_red.hit;
    assign o_sts.out_free = !r_out_valid || o_result.ready;

    // a dropped turn leaves the stack full, and reductions never follow it
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> int'(r_count) == PATH_DEPTH)
        else $error("overflow flag set with stack not full");

    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.out_load))
        else $error("result appeared without a load");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || o_result.ready))
        else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

/* rtl/gwf_ctrl.sv */
`default_nettype none

module gwf_ctrl import gwf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [15:0] {
        S_CLEAR    = 16'h0001,
        S_IDLE     = 16'h0002,
        S_DISP     = 16'h0004,
        S_LOOK_B   = 16'h0008,
        S_LOOK_C   = 16'h0010,
        S_DECIDE   = 16'h0020,
        S_MOVE     = 16'h0040,
        S_MARK     = 16'h0080,
        S_PUSH     = 16'h0100,
        S_RED_RD   = 16'h0200,
        S_RED_CHK  = 16'h0400,
        S_READ_CAP = 16'h0800,
        S_FIN_A    = 16'h1000,
        S_FIN_B    = 16'h2000,
        S_FIN_C    = 16'h4000,
        S_DONE     = 16'h8000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.gw_sel = GW_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.gw_sel   = GW_CLEAR;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready  = 1'b1;
                o_cmd.item_load = i_sts.in_valid;
                if (i_sts.in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                // north and east neighbours are read here for every operation
                unique case (i_sts.op)
                    OP_WRITE: begin
                        o_cmd.gw_sel = GW_CELL;
                        n_state      = S_FIN_A;
                    end
                    OP_STEP: begin
                        n_state = S_LOOK_B;
                    end
                    OP_READ: begin
                        n_state = S_READ_CAP;
                    end
                    OP_RESTART: begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_FIN_A;
                    end
                endcase
            end
            S_LOOK_B: begin
                o_cmd.cap_ne = 1'b1;
                o_cmd.rd_sw  = 1'b1;
                n_state      = S_LOOK_C;
            end
            S_LOOK_C: begin
                o_cmd.cap_sw = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.dec_load = 1'b1;
                n_state        = i_sts.goal ? S_DONE : S_MOVE;
            end
            S_MOVE: begin
                o_cmd.gw_sel = GW_OLD;
                o_cmd.move   = 1'b1;
                n_state      = S_MARK;
            end
            S_MARK: begin
                o_cmd.gw_sel = GW_NEW;
                n_state      = i_sts.push_req ? S_PUSH : S_FIN_A;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = i_sts.full ? S_FIN_A : S_RED_RD;
            end
            S_RED_RD: begin
                o_cmd.red_rd = 1'b1;
                n_state      = i_sts.ge3 ? S_RED_CHK : S_FIN_A;
            end
            S_RED_CHK: begin
                o_cmd.red_wr = i_sts.red_hit;
                n_state      = i_sts.red_hit ? S_RED_RD : S_FIN_A;
            end
            S_READ_CAP: begin
                o_cmd.entry_cap = 1'b1;
                n_state         = S_FIN_A;
            end
            S_FIN_A: begin
                n_state = S_FIN_B;
            end
            S_FIN_B: begin
                o_cmd.cap_ne = 1'b1;
                o_cmd.rd_sw  = 1'b1;
                n_state      = S_FIN_C;
            end
            S_FIN_C: begin
                o_cmd.cap_sw = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.item_load |=> !o_cmd.in_ready)
        else $error("second item taken while one is in work");

    a_red_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.red_wr |-> i_sts.ge3)
        else $error("path shortened with fewer than three turns");

    a_push_after_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> $past(o_cmd.gw_sel == GW_NEW))
        else $error("turn pushed without a completed move");

endmodule

`default_nettype wire

/* test/tb_grid_wall_follower_with_path_reduction.sv */
`timescale 1ns / 1ps

module tb_grid_wall_follower_with_path_reduction;
    import gwf_pkg::*;

    localparam int SIDE            = 32;
    localparam int DEPTH           = 128;
    localparam int ITEMS_PER_PHASE = 260;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [KIND_W-1:0]  kind;
        logic [IDX_W-1:0]   idx;
    } t_maze_cmd;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [HEAD_W-1:0]  head;
        logic [TURN_W-1:0]  turn;
        logic               goal;
        logic [LEN_W-1:0]   len;
        logic [ENTRY_W-1:0] entry;
        logic               ovf;
    } t_bot_status;

    logic clk;
    logic rst_n;

    gwf_item_if   item_ch ();
    gwf_result_if status_ch ();
    gwf_cfg_if    cfg_ch ();

    grid_wall_follower_with_path_reduction u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (status_ch),
        .i_cfg    (cfg_ch)
    );

    // walker model state
    logic [KIND_W-1:0]  maze_map [SIDE*SIDE];
    logic [ENTRY_W-1:0] path_stack [DEPTH];
    int unsigned        path_len;
    logic               path_ovf;
    logic [COORD_W-1:0] bot_row;
    logic [COORD_W-1:0] bot_col;
    logic [HEAD_W-1:0]  bot_head;
    logic [COORD_W-1:0] home_row;
    logic [COORD_W-1:0] home_col;
    logic [HEAD_W-1:0]  home_head;

    t_maze_cmd   cmds_pending [$];
    t_bot_status status_expected [$];
    t_maze_cmd   cmd_on_bus;
    t_bot_status status_want;
    int unsigned cmds_queued;
    int unsigned results_seen;
    int unsigned n_errors;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned n_steps, n_turns, n_shortened, n_dropped, n_reads, n_cfg;

    function automatic logic [KIND_W-1:0] kind_at(input int r, input int c);
        if (r < 0 || c < 0 || r >= SIDE || c >= SIDE) begin
            return KIND_BLANK;
        end
        return maze_map[r*SIDE + c];
    endfunction

    function automatic logic [KIND_W-1:0] kind_towards(input logic [HEAD_W-1:0] dir);
        int r;
        int c;
        r = int'(bot_row);
        c = int'(bot_col);
        case (dir)
            DIR_N:   r = r - 1;
            DIR_E:   c = c + 1;
            DIR_S:   r = r + 1;
            default: c = c - 1;
        endcase
        return kind_at(r, c);
    endfunction

    function automatic logic goal_in_sight();
        logic [HEAD_W-1:0] d;
        d = DIR_N;
        repeat (4) begin
            if (kind_towards(d) == KIND_GOAL) begin
                return 1'b1;
            end
            d = d + 2'd1;
        end
        return 1'b0;
    endfunction

    function automatic void move_bot(input logic [HEAD_W-1:0] dir);
        maze_map[{bot_row, bot_col}] = KIND_TRACK;
        case (dir)
            DIR_N:   bot_row = bot_row - 5'd1;
            DIR_E:   bot_col = bot_col + 5'd1;
            DIR_S:   bot_row = bot_row + 5'd1;
            default: bot_col = bot_col - 5'd1;
        endcase
        bot_head = dir;
        maze_map[{bot_row, bot_col}] = KIND_ROBOT;
    endfunction

    // x-back-y merge: {hit, merged turn}
    function automatic logic [2:0] shorten(input logic [ENTRY_W-1:0] a,
                                           input logic [ENTRY_W-1:0] c);
        case ({a, c})
            {PT_L, PT_R}, {PT_R, PT_L}, {PT_F, PT_F}: return {1'b1, PT_B};
            {PT_L, PT_F}, {PT_F, PT_L}:               return {1'b1, PT_R};
            {PT_L, PT_L}:                             return {1'b1, PT_F};
            default:                                  return 3'b000;
        endcase
    endfunction

    function automatic void record_turn(input logic [ENTRY_W-1:0] t);
        logic [2:0] merge;
        if (path_len >= DEPTH) begin
            path_ovf = 1'b1;
            n_dropped++;
            return;
        end
        path_stack[path_len] = t;
        path_len++;
        while (path_len >= 3 && path_stack[path_len-2] == PT_B) begin
            merge = shorten(path_stack[path_len-3], path_stack[path_len-1]);
            if (!merge[2]) begin
                break;
            end
            path_stack[path_len-3] = merge[ENTRY_W-1:0];
            path_len -= 2;
            n_shortened++;
        end
    endfunction

    function automatic logic [TURN_W-1:0] take_step();
        logic [HEAD_W-1:0] fwd;
        logic [HEAD_W-1:0] lft;
        logic [HEAD_W-1:0] rgt;
        fwd = bot_head;
        lft = bot_head - 2'd1;
        rgt = bot_head + 2'd1;
        if (goal_in_sight()) begin
            return TURN_NONE;
        end
        // plain corridor: move on without recording anything
        if (kind_towards(lft) == KIND_BLANK && kind_towards(rgt) == KIND_BLANK &&
            kind_towards(fwd) == KIND_TRACK) begin
            move_bot(fwd);
            return TURN_NONE;
        end
        n_turns++;
        if (kind_towards(lft) == KIND_TRACK) begin
            move_bot(lft);
            record_turn(PT_L);
            return TURN_LEFT;
        end
        if (kind_towards(fwd) == KIND_TRACK) begin
            move_bot(fwd);
            record_turn(PT_F);
            return TURN_FWD;
        end
        if (kind_towards(rgt) == KIND_TRACK) begin
            move_bot(rgt);
            record_turn(PT_R);
            return TURN_RIGHT;
        end
        move_bot(fwd + 2'd2);
        record_turn(PT_B);
        return TURN_BACK;
    endfunction

    function automatic void restart_bot();
        bot_row  = home_row;
        bot_col  = home_col;
        bot_head = home_head;
        path_len = 0;
        path_ovf = 1'b0;
    endfunction

    function automatic t_bot_status predict_status(input t_maze_cmd cmd);
        t_bot_status s;
        s.turn  = TURN_NONE;
        s.entry = '0;
        case (cmd.op)
            OP_WRITE: begin
                maze_map[{cmd.row, cmd.col}] = cmd.kind;
            end
            OP_STEP: begin
                n_steps++;
                s.turn = take_step();
            end
            OP_READ: begin
                n_reads++;
                if (cmd.idx < path_len) begin
                    s.entry = path_stack[cmd.idx];
                end
            end
            default: begin
                restart_bot();
            end
        endcase
        s.row  = bot_row;
        s.col  = bot_col;
        s.head = bot_head;
        s.goal = goal_in_sight();
        s.len  = path_len[LEN_W-1:0];
        s.ovf  = path_ovf;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    task automatic queue_cmd(input t_op op, input int r, input int c, input int k,
                             input int idx);
        t_maze_cmd cmd;
        cmd.op   = op;
        cmd.row  = r[COORD_W-1:0];
        cmd.col  = c[COORD_W-1:0];
        cmd.kind = k[KIND_W-1:0];
        cmd.idx  = idx[IDX_W-1:0];
        cmds_pending.push_back(cmd);
        cmds_queued++;
    endtask

    task automatic wait_idle();
        while (results_seen != cmds_queued) begin
            @(posedge clk);
        end
    endtask

    task automatic write_start(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val[CFG_DATA_W-1:0];
        do begin
            @(posedge clk);
        end while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_START_ROW:  home_row  = val[COORD_W-1:0];
            CFG_START_COL:  home_col  = val[COORD_W-1:0];
            CFG_START_HEAD: home_head = val[HEAD_W-1:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic clear_around(input int r0, input int c0, input int rad);
        for (int r = r0 - rad; r <= r0 + rad; r++) begin
            for (int c = c0 - rad; c <= c0 + rad; c++) begin
                if (kind_at(r, c) != KIND_BLANK) begin
                    queue_cmd(OP_WRITE, r, c, KIND_BLANK, $urandom);
                end
            end
        end
    endtask

    // random track walk from the start cell, then a walk of the robot over it
    task automatic maze_episode();
        int r0, c0, r, c, nr, nc, n, run, nsteps, roll;
        logic [HEAD_W-1:0] dir;
        r0 = int'(home_row);
        c0 = int'(home_col);
        r  = r0;
        c  = c0;
        queue_cmd(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
        clear_around(r0, c0, 5);
        n = $urandom_range(30, 6);
        for (int i = 0; i < n; i++) begin
            dir = HEAD_W'($urandom_range(3));
            run = $urandom_range(3, 1);
            for (int j = 0; j < run; j++) begin
                nr = r;
                nc = c;
                case (dir)
                    DIR_N:   nr = r - 1;
                    DIR_E:   nc = c + 1;
                    DIR_S:   nr = r + 1;
                    default: nc = c - 1;
                endcase
                if (nr >= 0 && nr < SIDE && nc >= 0 && nc < SIDE &&
                    nr >= r0 - 5 && nr <= r0 + 5 && nc >= c0 - 5 && nc <= c0 + 5) begin
                    r = nr;
                    c = nc;
                    queue_cmd(OP_WRITE, r, c, KIND_TRACK, $urandom);
                end
            end
        end
        if ($urandom_range(2) == 0) begin
            queue_cmd(OP_WRITE, r, c, KIND_GOAL, $urandom);
        end
        nsteps = $urandom_range(3 * n, n + 2);
        for (int i = 0; i < nsteps; i++) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                queue_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom_range(15));
            end else if (roll < 15) begin
                queue_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom_range(127));
            end else if (roll < 19) begin
                queue_cmd(OP_WRITE, r0 + $urandom_range(10) - 5, c0 + $urandom_range(10) - 5,
                          $urandom_range(7), $urandom);
            end else begin
                queue_cmd(OP_STEP, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    // closed 3x3 loop: every lap pushes turns that never merge, so the path fills
    task automatic ring_episode();
        int r0, c0, nsteps;
        r0 = int'(home_row);
        c0 = int'(home_col);
        queue_cmd(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
        clear_around(r0 + 1, c0 + 1, 3);
        for (int i = 0; i <= 2; i++) begin
            for (int j = 0; j <= 2; j++) begin
                if ((i != 1 || j != 1) && r0 + i < SIDE && c0 + j < SIDE) begin
                    queue_cmd(OP_WRITE, r0 + i, c0 + j, KIND_TRACK, $urandom);
                end
            end
        end
        nsteps = $urandom_range(300, 270);
        for (int i = 0; i < nsteps; i++) begin
            if ($urandom_range(9) == 0) begin
                queue_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom_range(127));
            end else begin
                queue_cmd(OP_STEP, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic noise_episode();
        int n, roll;
        n = $urandom_range(40, 15);
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                queue_cmd(OP_WRITE, $urandom, $urandom, $urandom_range(7), $urandom);
            end else if (roll < 75) begin
                queue_cmd(OP_STEP, $urandom, $urandom, $urandom, $urandom);
            end else if (roll < 95) begin
                queue_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom);
            end else begin
                queue_cmd(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("timeout: %0d of %0d results seen", results_seen, cmds_queued);
        $display("end of test: mismatches");
        $finish;
    end

    // item driver: the model is advanced on each accepted transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                status_expected.push_back(predict_status(cmd_on_bus));
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (cmds_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_on_bus = cmds_pending.pop_front();
                    item_ch.valid       <= 1'b1;
                    item_ch.operation   <= cmd_on_bus.op;
                    item_ch.cell_row    <= cmd_on_bus.row;
                    item_ch.cell_col    <= cmd_on_bus.col;
                    item_ch.cell_kind   <= cmd_on_bus.kind;
                    item_ch.entry_index <= cmd_on_bus.idx;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            status_ch.ready <= 1'b0;
        end else begin
            if (status_ch.valid && status_ch.ready) begin
                results_seen++;
                if (status_expected.size() == 0) begin
                    $error("result transfer with no item outstanding");
                    n_errors++;
                end else begin
                    status_want = status_expected.pop_front();
                    check_field("robot_row", status_want.row, status_ch.robot_row);
                    check_field("robot_col", status_want.col, status_ch.robot_col);
                    check_field("robot_heading", status_want.head, status_ch.robot_heading);
                    check_field("turn_taken", status_want.turn, status_ch.turn_taken);
                    check_field("reached_goal", status_want.goal, status_ch.reached_goal);
                    check_field("path_length", status_want.len, status_ch.path_length);
                    check_field("path_entry", status_want.entry, status_ch.path_entry);
                    check_field("path_overflow", status_want.ovf, status_ch.path_overflow);
                end
            end
            status_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int budget, roll, cr, cc, ch;
        logic first_ep;
        rst_n = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.operation   = '0;
        item_ch.cell_row    = '0;
        item_ch.cell_col    = '0;
        item_ch.cell_kind   = '0;
        item_ch.entry_index = '0;
        status_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        cmds_queued  = 0;
        results_seen = 0;
        n_errors     = 0;
        n_steps      = 0;
        n_turns      = 0;
        n_shortened  = 0;
        n_dropped    = 0;
        n_reads      = 0;
        n_cfg        = 0;
        send_idle_pct = 37;
        recv_idle_pct = 55;
        home_row  = START_ROW_RST;
        home_col  = START_COL_RST;
        home_head = START_HEAD_RST;
        foreach (maze_map[i]) begin
            maze_map[i] = KIND_BLANK;
        end
        restart_bot();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // hand-built corner from the reset start: corridor, left, back, a
        // forward that folds the path, right, goal in sight, reads, restart
        queue_cmd(OP_READ, 0, 0, 0, 0);
        queue_cmd(OP_WRITE, 12, 2, KIND_TRACK, 0);
        queue_cmd(OP_WRITE, 11, 2, KIND_TRACK, 0);
        queue_cmd(OP_STEP, 0, 0, 0, 0);
        queue_cmd(OP_STEP, 31, 31, 7, 127);
        queue_cmd(OP_STEP, 0, 0, 0, 0);
        queue_cmd(OP_WRITE, 12, 3, 5, 0);
        queue_cmd(OP_WRITE, 13, 2, KIND_TRACK, 0);
        queue_cmd(OP_STEP, 0, 0, 0, 0);
        queue_cmd(OP_WRITE, 13, 1, KIND_TRACK, 0);
        queue_cmd(OP_STEP, 0, 0, 0, 0);
        queue_cmd(OP_WRITE, 14, 1, KIND_GOAL, 127);
        queue_cmd(OP_STEP, 0, 0, 0, 0);
        queue_cmd(OP_READ, 0, 0, 0, 0);
        queue_cmd(OP_READ, 0, 0, 0, 1);
        queue_cmd(OP_READ, 31, 31, 7, 127);
        queue_cmd(OP_WRITE, 31, 31, 7, 0);
        queue_cmd(OP_WRITE, 0, 0, 4, 0);
        queue_cmd(OP_WRITE, 0, 31, KIND_ROBOT, 0);
        queue_cmd(OP_RESTART, 0, 0, 0, 0);
        queue_cmd(OP_READ, 0, 0, 0, 0);
        queue_cmd(OP_WRITE, 14, 1, KIND_BLANK, 0);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 37;
                recv_idle_pct = 55;
            end else if (ph < 4) begin
                send_idle_pct = 55;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: begin
                    cr = 0;
                    cc = 0;
                    ch = DIR_S;
                end
                1: begin
                    cr = 31;
                    cc = 31;
                    ch = DIR_W;
                end
                3: begin
                    cr = 0;
                    cc = 31;
                    ch = DIR_N;
                end
                default: begin
                    cr = $urandom_range(29);
                    cc = $urandom_range(29);
                    ch = $urandom_range(3);
                end
            endcase
            wait_idle();
            write_start(CFG_START_ROW, cr);
            write_start(CFG_START_COL, cc);
            write_start(CFG_START_HEAD, ch);
            cfg_ch.valid <= 1'b0;

            // blank surroundings at the start: back moves wrap at the edges
            queue_cmd(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
            clear_around(int'(home_row), int'(home_col), 1);
            repeat (3) queue_cmd(OP_STEP, $urandom, $urandom, $urandom, $urandom);
            queue_cmd(OP_READ, $urandom, $urandom, $urandom, 0);
            queue_cmd(OP_READ, $urandom, $urandom, $urandom, 1);

            budget   = cmds_queued + ITEMS_PER_PHASE;
            first_ep = 1'b1;
            while (cmds_queued < budget) begin
                // each episode is planned from the settled map
                wait_idle();
                roll = $urandom_range(99);
                if ((first_ep && (ph == 0 || ph == 2)) || roll < 6) begin
                    ring_episode();
                end else if (roll < 70) begin
                    maze_episode();
                end else begin
                    noise_episode();
                end
                first_ep = 1'b0;
            end
        end

        wait_idle();
        repeat (300) @(posedge clk);
        $display("run covered %0d items: %0d steps with %0d turns, %0d path merges, %0d reads",
                 cmds_queued, n_steps, n_turns, n_shortened, n_reads);
        $display("%0d start register writes, %0d turns lost to a full path, %0d errors",
                 n_cfg, n_dropped, n_errors);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/gwf_pkg.sv
rtl/gwf_if.sv
rtl/gwf_dp.sv
rtl/gwf_ctrl.sv
rtl/grid_wall_follower_with_path_reduction.sv
test/tb_grid_wall_follower_with_path_reduction.sv
